@@ hw/rtl/lsb_stego_extractor_core_macros.svh @@
// ----------------------------------------------------------------------------
// lsb_stego_extractor_core_macros.svh
// Assertion macros used by the checker file of the extractor.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_EXTRACTOR_CORE_MACROS_SVH
`define LSB_STEGO_EXTRACTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lse: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lse: next-cycle check failed");

`endif

@@ hw/rtl/lse_pkg.sv @@
// ----------------------------------------------------------------------------
// lse_pkg
// Types and constants shared by the LSB extractor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

	// Extension length must be nonzero and below this many bytes
	localparam int unsigned EXT_BUFFER = 8;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SKIP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LEN   = 2'd2;

	localparam logic [9:0]  HEADER_SKIP_RST = 10'd54;
	localparam logic [31:0] MAGIC_WORD_RST  = 32'd0;
	localparam logic [2:0]  MAGIC_LEN_RST   = 3'd2;

	// Result kinds
	localparam logic [1:0] KIND_EXT = 2'd0;
	localparam logic [1:0] KIND_PAY = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_MAGIC   = 2'd1;
	localparam logic [1:0] ERR_EXT_LEN = 2'd2;
	localparam logic [1:0] ERR_PAY_LEN = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_HEADER  = 3'd1,
		PH_MAGIC   = 3'd2,
		PH_EXTLEN  = 3'd3,
		PH_EXT     = 3'd4,
		PH_PAYLEN  = 3'd5,
		PH_PAYLOAD = 3'd6,
		PH_STOP    = 3'd7
	} phase_t;

	typedef struct packed {
		logic lsb;
		logic frame_start;
	} item_t;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic [1:0] err;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/lse_decoder.sv @@
// ----------------------------------------------------------------------------
// lse_decoder
// Configuration registers, frame parser state and per-byte decode logic.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             consume,
	input  lse_pkg::item_t                   item,
	input  logic                             cfg_write,
	input  logic [lse_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lse_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             res_valid,
	output lse_pkg::result_t                 res
);
	import lse_pkg::*;

	logic [9:0]  header_skip_q;
	logic [31:0] magic_word_q;
	logic [2:0]  magic_len_q;

	phase_t      phase_q, phase_n;
	logic [4:0]  bidx_q, bidx_n;
	logic [31:0] shift_q, shift_n;
	logic [31:0] cnt_q, cnt_n;
	logic [9:0]  hcnt_q, hcnt_n;
	logic [31:0] len_q, len_n;

	phase_t      ph_a, ph_e;
	logic [9:0]  hcnt_a;
	logic        start_magic;
	logic [4:0]  bidx_e, bidx_inc;
	logic [31:0] cnt_e;
	logic [31:0] word;
	logic        byte_done, word_done;
	logic [2:0]  mlen;
	logic [1:0]  pos;
	logic [7:0]  exp_byte;
	logic [32:0] cnt_inc;
	logic        cnt_fin, magic_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_skip_q <= HEADER_SKIP_RST;
			magic_word_q  <= MAGIC_WORD_RST;
			magic_len_q   <= MAGIC_LEN_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_HEADER_SKIP: header_skip_q <= cfg_data[9:0];
				CFG_MAGIC_WORD:  magic_word_q  <= cfg_data;
				CFG_MAGIC_LEN:   magic_len_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (magic_len_q)
			3'd0:                   mlen = 3'd1;
			3'd1, 3'd2, 3'd3, 3'd4: mlen = magic_len_q;
			default:                mlen = 3'd4;
		endcase
	end

	always_comb begin
		// frame start restarts the parser with this very byte
		ph_a        = item.frame_start ? PH_HEADER : phase_q;
		hcnt_a      = item.frame_start ? '0 : hcnt_q;
		start_magic = (ph_a == PH_HEADER) && (hcnt_a >= header_skip_q);
		ph_e        = start_magic ? PH_MAGIC : ph_a;
		bidx_e      = start_magic ? '0 : bidx_q;
		cnt_e       = start_magic ? '0 : cnt_q;

		word      = {shift_q[30:0], item.lsb};
		byte_done = (bidx_e == 5'd7);
		word_done = (bidx_e == 5'd31);
		bidx_inc  = bidx_e + 5'd1;
		cnt_inc   = {1'b0, cnt_e} + 33'd1;
		cnt_fin   = (cnt_inc >= {1'b0, len_q});
		magic_fin = (cnt_inc >= {30'd0, mlen});

		// signature byte position; a shrunk magic_len falls back to byte 0
		pos      = (cnt_e < {29'd0, mlen}) ? 2'(mlen - 3'd1 - cnt_e[2:0]) : 2'd0;
		exp_byte = magic_word_q[{pos, 3'b000} +: 8];

		phase_n   = ph_e;
		hcnt_n    = hcnt_a;
		bidx_n    = bidx_e;
		cnt_n     = cnt_e;
		shift_n   = shift_q;
		len_n     = len_q;
		res_valid = 1'b0;
		res       = '0;

		unique case (ph_e)
			PH_HEADER: hcnt_n = hcnt_a + 10'd1;
			PH_MAGIC: begin
				shift_n = word;
				bidx_n  = byte_done ? '0 : bidx_inc;
				if (byte_done) begin
					if (word[7:0] != exp_byte) begin
						phase_n   = PH_STOP;
						res_valid = 1'b1;
						res.kind  = KIND_ERR;
						res.err   = ERR_MAGIC;
					end else if (magic_fin) begin
						phase_n = PH_EXTLEN;
						cnt_n   = '0;
					end else begin
						cnt_n = cnt_inc[31:0];
					end
				end
			end
			PH_EXTLEN: begin
				shift_n = word;
				bidx_n  = word_done ? '0 : bidx_inc;
				if (word_done) begin
					if (word == 32'd0 || word >= 32'(EXT_BUFFER)) begin
						phase_n   = PH_STOP;
						res_valid = 1'b1;
						res.kind  = KIND_ERR;
						res.err   = ERR_EXT_LEN;
					end else begin
						len_n   = word;
						phase_n = PH_EXT;
						cnt_n   = '0;
					end
				end
			end
			PH_EXT: begin
				shift_n = word;
				bidx_n  = byte_done ? '0 : bidx_inc;
				if (byte_done) begin
					res_valid = 1'b1;
					res.data  = word[7:0];
					res.kind  = KIND_EXT;
					res.last  = cnt_fin;
					if (cnt_fin) begin
						phase_n = PH_PAYLEN;
						cnt_n   = '0;
					end else begin
						cnt_n = cnt_inc[31:0];
					end
				end
			end
			PH_PAYLEN: begin
				shift_n = word;
				bidx_n  = word_done ? '0 : bidx_inc;
				if (word_done) begin
					if (word == 32'd0) begin
						phase_n   = PH_STOP;
						res_valid = 1'b1;
						res.kind  = KIND_ERR;
						res.err   = ERR_PAY_LEN;
					end else begin
						len_n   = word;
						phase_n = PH_PAYLOAD;
						cnt_n   = '0;
					end
				end
			end
			PH_PAYLOAD: begin
				shift_n = word;
				bidx_n  = byte_done ? '0 : bidx_inc;
				if (byte_done) begin
					res_valid = 1'b1;
					res.data  = word[7:0];
					res.kind  = KIND_PAY;
					res.last  = cnt_fin;
					cnt_n     = cnt_inc[31:0];
					if (cnt_fin) begin
						phase_n = PH_STOP;
					end
				end
			end
			PH_IDLE, PH_STOP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bidx_q  <= '0;
			cnt_q   <= '0;
			hcnt_q  <= '0;
			len_q   <= '0;
		end else if (consume) begin
			phase_q <= phase_n;
			bidx_q  <= bidx_n;
			cnt_q   <= cnt_n;
			hcnt_q  <= hcnt_n;
			len_q   <= len_n;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			shift_q <= shift_n;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lse_out_reg.sv @@
// ----------------------------------------------------------------------------
// lse_out_reg
// Result register holding one transaction for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load_valid,
	input  lse_pkg::result_t load_res,
	input  logic             out_stall,
	output logic             ready,
	output logic             out_valid,
	output lse_pkg::result_t out_res
);
	import lse_pkg::*;

	logic    valid_q;
	result_t res_q;

	// register can take a new result when empty or when its content leaves now
	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load_valid) begin
			res_q <= load_res;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lsb_stego_extractor_core.sv @@
// ----------------------------------------------------------------------------
// lsb_stego_extractor_core
// Recovers hidden bytes from the LSBs of an image byte stream.
// ----------------------------------------------------------------------------
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, pixel_byte, frame_start | sink
//  out     | out_valid, out_stall, out_byte, out_kind,  | source
//          | error_code, last                           |
//  cfg     | cfg_write, cfg_index, cfg_data             | sink
//
//  One image byte per cycle while in_stall is low; each is registered, then
//  passes the single decode stage before its result loads the result register.
//  in_stall rises only while the result register is full and out_stall is high.
//  arst_n clears the parser to wait for a frame start and loads config defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_stego_extractor_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       pixel_byte,
	input  logic                             frame_start,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_byte,
	output logic [1:0]                       out_kind,
	output logic [1:0]                       error_code,
	output logic                             last,
	input  logic                             cfg_write,
	input  logic [lse_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lse_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lse_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_ready;
	logic    consume;
	logic    in_accept;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign consume   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// only bit 0 of the image byte carries hidden data
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.lsb         <= pixel_byte[0];
			item_s1.frame_start <= frame_start;
		end
	end

	lse_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.consume   (consume),
		.item      (item_s1),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res       (res)
	);

	lse_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (consume && res_valid),
		.load_res   (res),
		.out_stall  (out_stall),
		.ready      (out_ready),
		.out_valid  (out_valid),
		.out_res    (out_res)
	);

	assign out_byte   = out_res.data;
	assign out_kind   = out_res.kind;
	assign error_code = out_res.err;
	assign last       = out_res.last;

endmodule

`default_nettype wire

@@ hw/rtl/lse_checker.sv @@
// ----------------------------------------------------------------------------
// lse_checker
// Port-level checks on the extractor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lsb_stego_extractor_core_macros.svh"

module lse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic [1:0] out_kind,
	input logic [1:0] error_code,
	input logic       last
);
	import lse_pkg::*;

	// a stalled result transaction holds
	`LSE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_kind) && $stable(error_code) && $stable(last))

	// error reports carry a code and no data
	`LSE_ASSERT_IMP(a_err_fields, clk, arst_n, out_valid && out_kind == KIND_ERR, out_byte == 8'd0 && !last && error_code != ERR_NONE)

	// data results are extension or payload bytes with no error code
	`LSE_ASSERT_IMP(a_data_fields, clk, arst_n, out_valid && out_kind != KIND_ERR, (out_kind == KIND_EXT || out_kind == KIND_PAY) && error_code == ERR_NONE)

	// input back-pressure only comes from a full, stalled result register
	`LSE_ASSERT_IMP(a_in_stall_src, clk, arst_n, in_stall, out_valid && out_stall)

endmodule

bind lsb_stego_extractor_core lse_checker u_lse_checker (.*);

`default_nettype wire

@@ test/tb_lsb_stego_extractor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lsb_stego_extractor_core
// Streams image bytes with hidden frames into the extractor and checks every
// recovered byte and error report against a cycle-free decoder kept in the
// bench. Covers directed corner frames, then random frames under random
// sender gaps and receiver stalls, with config changes between bursts.
// ----------------------------------------------------------------------------

module tb_lsb_stego_extractor_core;
	import lse_pkg::*;

	localparam int unsigned PAY_SENT_MAX = 4;
	localparam int unsigned ITEM_TARGET  = 950;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            pixel_byte;
	logic                  frame_start;
	logic                  out_valid;
	logic                  out_stall;
	logic [7:0]            out_byte;
	logic [1:0]            out_kind;
	logic [1:0]            error_code;
	logic                  last;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lsb_stego_extractor_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_byte (pixel_byte),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.out_kind   (out_kind),
		.error_code (error_code),
		.last       (last),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Decoder state mirrored per accepted pixel; holds the results still owed.
	class hidden_data_tracker;
		logic [9:0]  skip_reg;
		logic [31:0] magic_reg;
		logic [2:0]  mlen_reg;
		phase_t      ph;
		int unsigned bit_pos;
		logic [31:0] gather_word;
		int unsigned field_count;
		logic [9:0]  hdr_count;
		logic [31:0] ext_len;
		logic [31:0] pay_len;
		result_t     due[$];
		int unsigned live_count;
		int unsigned result_count;
		int unsigned fail_count;
		int unsigned kind_seen[4];
		int unsigned err_seen[4];

		function new();
			skip_reg    = HEADER_SKIP_RST;
			magic_reg   = MAGIC_WORD_RST;
			mlen_reg    = MAGIC_LEN_RST;
			ph          = PH_IDLE;
			bit_pos     = 0;
			gather_word = '0;
			field_count = 0;
			hdr_count   = '0;
			ext_len     = '0;
			pay_len     = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				CFG_HEADER_SKIP: skip_reg  = val[9:0];
				CFG_MAGIC_WORD:  magic_reg = val;
				CFG_MAGIC_LEN:   mlen_reg  = val[2:0];
				default: ;
			endcase
		endfunction

		function int unsigned sig_bytes();
			if (mlen_reg == 0) return 1;
			if (mlen_reg > 4) return 4;
			return mlen_reg;
		endfunction

		function void open_field(phase_t nxt);
			ph          = nxt;
			bit_pos     = 0;
			gather_word = '0;
			field_count = 0;
		endfunction

		// MSB-first gather; returns 1 once `need` bits are in
		function bit shift_bit(logic b, int unsigned need);
			gather_word = {gather_word[30:0], b};
			if (bit_pos + 1 >= need) begin
				bit_pos = 0;
				return 1'b1;
			end
			bit_pos = (bit_pos + 1) & 31;
			return 1'b0;
		endfunction

		function void owe(logic [7:0] d, logic [1:0] k, logic [1:0] e, logic l);
			due.push_back('{data: d, kind: k, err: e, last: l});
		endfunction

		function void take_pixel(logic [7:0] pix, logic fs);
			int unsigned len;
			int unsigned pos;
			logic [7:0]  sig;
			logic        fin;
			if (fs) begin
				open_field(PH_HEADER);
				hdr_count = '0;
				ext_len   = '0;
				pay_len   = '0;
			end
			if (ph != PH_IDLE && ph != PH_STOP)
				live_count++;
			if (ph == PH_HEADER) begin
				if (hdr_count < skip_reg) begin
					hdr_count = hdr_count + 1'b1;
					return;
				end
				open_field(PH_MAGIC);
			end
			case (ph)
				PH_MAGIC: begin
					len = sig_bytes();
					if (!shift_bit(pix[0], 8)) return;
					pos = (field_count < len) ? len - 1 - field_count : 0;
					sig = magic_reg[8*pos +: 8];
					if (gather_word[7:0] != sig) begin
						ph = PH_STOP;
						owe(8'd0, KIND_ERR, ERR_MAGIC, 1'b0);
						return;
					end
					field_count++;
					gather_word = '0;
					if (field_count >= len) open_field(PH_EXTLEN);
				end
				PH_EXTLEN: begin
					if (!shift_bit(pix[0], 32)) return;
					if (gather_word == 0 || gather_word >= EXT_BUFFER) begin
						ph = PH_STOP;
						owe(8'd0, KIND_ERR, ERR_EXT_LEN, 1'b0);
						return;
					end
					ext_len = gather_word;
					open_field(PH_EXT);
				end
				PH_EXT: begin
					if (!shift_bit(pix[0], 8)) return;
					field_count++;
					fin = (field_count >= ext_len);
					owe(gather_word[7:0], KIND_EXT, ERR_NONE, fin);
					gather_word = '0;
					if (fin) open_field(PH_PAYLEN);
				end
				PH_PAYLEN: begin
					if (!shift_bit(pix[0], 32)) return;
					if (gather_word == 0) begin
						ph = PH_STOP;
						owe(8'd0, KIND_ERR, ERR_PAY_LEN, 1'b0);
						return;
					end
					pay_len = gather_word;
					open_field(PH_PAYLOAD);
				end
				PH_PAYLOAD: begin
					if (!shift_bit(pix[0], 8)) return;
					field_count++;
					fin = (field_count >= pay_len);
					owe(gather_word[7:0], KIND_PAY, ERR_NONE, fin);
					gather_word = '0;
					if (fin) ph = PH_STOP;
				end
				default: ;
			endcase
		endfunction

		function void match_result(result_t got);
			result_t want;
			result_count++;
			if (due.size() == 0) begin
				$error("unexpected result: out_byte %0h out_kind %0d error_code %0d last %0d",
					got.data, got.kind, got.err, got.last);
				fail_count++;
				return;
			end
			want = due.pop_front();
			kind_seen[want.kind]++;
			if (want.kind == KIND_ERR) err_seen[want.err]++;
			if (got.data !== want.data) begin
				$error("out_byte: expected %0h, actual %0h", want.data, got.data);
				fail_count++;
			end
			if (got.kind !== want.kind) begin
				$error("out_kind: expected %0d, actual %0d", want.kind, got.kind);
				fail_count++;
			end
			if (got.err !== want.err) begin
				$error("error_code: expected %0d, actual %0d", want.err, got.err);
				fail_count++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				fail_count++;
			end
		endfunction
	endclass

	hidden_data_tracker tracker;

	item_t       pixel_q[$];
	bit          start_mark;
	logic [9:0]  cur_skip;
	logic [31:0] cur_magic;
	logic [2:0]  cur_mlen;
	int unsigned burst_left;
	int unsigned frames_built;
	int unsigned cfg_writes;
	int unsigned sent_count;
	int unsigned stall_left;
	int unsigned stall_mode;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#10_000_000;
		$display("lsb_stego_extractor_core: mismatch");
		$finish;
	end

	// Receiver: stretches of no stall, random stall, mostly-stalled, and stall early in the stretch
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			2: out_stall <= (stall_left[1:0] != 2'd0);
			default: out_stall <= (stall_left > 90);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.take_pixel(pixel_byte, frame_start);
			if (out_valid && !out_stall)
				tracker.match_result('{data: out_byte, kind: out_kind, err: error_code,
					last: last});
		end
	end

	function automatic int unsigned sig_len(logic [2:0] m);
		if (m == 0) return 1;
		if (m > 4) return 4;
		return m;
	endfunction

	function automatic void add_bit(logic b);
		pixel_q.push_back('{lsb: b, frame_start: start_mark});
		start_mark = 1'b0;
	endfunction

	function automatic void add_bits(logic [31:0] v, int n);
		for (int i = n - 1; i >= 0; i--)
			add_bit(v[i]);
	endfunction

	function automatic void add_noise(int unsigned n);
		repeat (n) add_bit($urandom);
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return $urandom;
		endcase
	endfunction

	// One frame as hidden bits; bad_at corrupts that signature byte, cut keeps
	// only the first items so the next frame start lands mid-frame.
	function automatic void add_frame(int unsigned hdr_n, logic [31:0] ext_n,
		logic [31:0] pay_n, int bad_at, int unsigned cut);
		int unsigned first;
		int unsigned ml;
		logic [7:0]  sb;
		bit          dead;
		first      = pixel_q.size();
		start_mark = 1'b1;
		dead       = 1'b0;
		repeat (hdr_n) add_bit($urandom);
		ml = sig_len(cur_mlen);
		for (int i = 0; i < ml && !dead; i++) begin
			sb = cur_magic[8*(ml-1-i) +: 8];
			if (i == bad_at) begin
				sb   = sb ^ 8'($urandom_range(1, 255));
				dead = 1'b1;
			end
			add_bits(sb, 8);
		end
		if (!dead) begin
			add_bits(ext_n, 32);
			dead = (ext_n == 0 || ext_n >= EXT_BUFFER);
		end
		if (!dead)
			for (int unsigned n = 0; n < ext_n; n++) add_bits(rand_byte(), 8);
		if (!dead) begin
			add_bits(pay_n, 32);
			dead = (pay_n == 0);
		end
		if (!dead)
			for (int unsigned n = 0; n < pay_n && n < PAY_SENT_MAX; n++)
				add_bits(rand_byte(), 8);
		// a frame with no items left would lose its start mark
		if (start_mark) add_bit($urandom);
		start_mark = 1'b0;
		if (cut != 0)
			while (pixel_q.size() > first + cut) void'(pixel_q.pop_back());
		frames_built++;
	endfunction

	function automatic void add_random_frame();
		int unsigned ml;
		logic [31:0] bad_len;
		ml = sig_len(cur_mlen);
		case ($urandom_range(0, 15))
			10: add_frame(cur_skip, $urandom_range(1, 7), $urandom_range(1, 6),
				$urandom_range(0, ml - 1), 0);
			11: begin
				case ($urandom_range(0, 2))
					0: bad_len = 0;
					1: bad_len = $urandom_range(EXT_BUFFER, 255);
					default: begin
						bad_len = $urandom;
						if (bad_len < EXT_BUFFER) bad_len = bad_len + EXT_BUFFER;
					end
				endcase
				add_frame(cur_skip, bad_len, 1, -1, 0);
			end
			12: add_frame(cur_skip, $urandom_range(1, 7), 0, -1, 0);
			13: add_frame(cur_skip, $urandom_range(1, 7), $urandom | 32'h100, -1, 0);
			14: add_frame(cur_skip, $urandom_range(1, 7), $urandom_range(1, 6), -1,
				$urandom_range(1, cur_skip + 120));
			15: add_noise($urandom_range(1, 5));
			default: add_frame(cur_skip, $urandom_range(1, 7),
				($urandom_range(0, 3) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6),
				-1, 0);
		endcase
	endfunction

	// Sender works in bursts; valid only drops when a gap is actually taken.
	task automatic send_pixel(logic lsb, logic fs);
		logic [6:0]  hi;
		int unsigned gap;
		hi = $urandom;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		pixel_byte  <= {hi, lsb};
		frame_start <= fs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_queued(int unsigned n);
		item_t it;
		repeat (n) begin
			if (pixel_q.size() != 0) begin
				it = pixel_q.pop_front();
				send_pixel(it.lsb, it.frame_start);
				sent_count++;
			end
		end
	endtask

	// Drop valid, wait out every owed result plus the pipeline depth.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		tracker.set_reg(idx, val);
		case (idx)
			CFG_HEADER_SKIP: cur_skip  = val[9:0];
			CFG_MAGIC_WORD:  cur_magic = val;
			CFG_MAGIC_LEN:   cur_mlen  = val[2:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	initial begin
		tracker     = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		pixel_byte  = 8'd0;
		frame_start = 1'b0;
		out_stall   = 1'b0;
		cfg_write   = 1'b0;
		cfg_index   = CFG_HEADER_SKIP;
		cfg_data    = '0;
		cur_skip    = HEADER_SKIP_RST;
		cur_magic   = MAGIC_WORD_RST;
		cur_mlen    = MAGIC_LEN_RST;
		start_mark  = 1'b0;
		burst_left  = 0;
		sent_count  = 0;
		stall_left  = 0;
		stall_mode  = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset defaults: noise before any frame start, one clean frame, bytes after it
		add_noise(4);
		add_frame(cur_skip, 1, 1, -1, 0);
		add_noise(3);
		send_queued(pixel_q.size());
		settle();

		// No header; signature length above four acts as four, all-ones signature
		write_reg(CFG_HEADER_SKIP, 0);
		write_reg(CFG_MAGIC_WORD, 32'hFFFF_FFFF);
		write_reg(CFG_MAGIC_LEN, 7);
		add_frame(0, EXT_BUFFER - 1, 1, -1, 0);
		add_noise(2);
		add_frame(0, EXT_BUFFER, 1, -1, 0);
		add_frame(0, 2, 2, 3, 0);
		// huge payload length, cut by the next frame start
		add_frame(0, 1, 32'hFFFF_FFFF, -1, 0);
		send_queued(pixel_q.size());
		settle();

		// Signature length zero acts as one byte; zero extension and payload lengths
		write_reg(CFG_MAGIC_LEN, 0);
		write_reg(CFG_MAGIC_WORD, 32'h0000_00C3);
		write_reg(CFG_HEADER_SKIP, 1);
		add_frame(1, 0, 1, -1, 0);
		add_frame(1, 1, 0, -1, 0);
		add_frame(1, 3, 2, 0, 0);
		add_noise(2);
		send_queued(pixel_q.size());
		settle();

		// Header length changed while the frame sits in its header
		write_reg(CFG_HEADER_SKIP, 10);
		add_frame(4, 2, 2, -1, 0);
		send_queued(3);
		settle();
		write_reg(CFG_HEADER_SKIP, 4);
		send_queued(pixel_q.size());
		settle();

		// Random frames until the item budget is spent
		while (sent_count < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: write_reg(CFG_HEADER_SKIP, $urandom_range(7, 70));
				1: write_reg(CFG_HEADER_SKIP, 0);
				default: write_reg(CFG_HEADER_SKIP, $urandom_range(0, 6));
			endcase
			write_reg(CFG_MAGIC_WORD, $urandom);
			write_reg(CFG_MAGIC_LEN, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
				: $urandom_range(1, 4));
			repeat ($urandom_range(1, 2)) add_random_frame();
			send_queued(pixel_q.size());
			settle();
		end

		$display("Sent %0d image bytes (%0d inside frames) over %0d frames, %0d writes.",
			sent_count, tracker.live_count, frames_built, cfg_writes);
		$display("%0d results: %0d ext, %0d payload, %0d errors (%0d/%0d/%0d).",
			tracker.result_count, tracker.kind_seen[KIND_EXT],
			tracker.kind_seen[KIND_PAY], tracker.kind_seen[KIND_ERR],
			tracker.err_seen[ERR_MAGIC], tracker.err_seen[ERR_EXT_LEN],
			tracker.err_seen[ERR_PAY_LEN]);
		if (tracker.fail_count == 0 && tracker.due.size() == 0)
			$display("lsb_stego_extractor_core: match");
		else
			$display("lsb_stego_extractor_core: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lse_pkg.sv
hw/rtl/lse_decoder.sv
hw/rtl/lse_out_reg.sv
hw/rtl/lsb_stego_extractor_core.sv
hw/rtl/lse_checker.sv
test/tb_lsb_stego_extractor_core.sv
